// ===== design/rps_pkg.sv =====
`timescale 1ns / 1ps

package rps_pkg;

   localparam int unsigned TEMP_W   = 16;
   localparam int unsigned DEG_W    = 9;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned TIMER_W  = 20;
   localparam int unsigned ERR_W    = 4;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 20;

   typedef enum logic [2:0] {
      STAGE_IDLE    = 3'd0,
      STAGE_PREHEAT = 3'd1,
      STAGE_SOAK    = 3'd2,
      STAGE_REFLOW  = 3'd3,
      STAGE_COOL    = 3'd4,
      STAGE_ABORT   = 3'd5
   } stage_type;

   typedef enum logic [1:0] {
      MODE_TICK      = 2'd0,
      MODE_START     = 2'd1,
      MODE_ABORT     = 2'd2,
      MODE_CLEAR_ERR = 2'd3
   } mode_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PREHEAT_SETPOINT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREHEAT_EXIT_TEMP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOAK_SETPOINT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOAK_TIME_MS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REFLOW_SETPOINT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REFLOW_EXIT_TEMP  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COOL_EXIT_TEMP    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_PERIOD_MS  = 3'd7;

   // Register reset values
   localparam logic [DEG_W-1:0]    RST_PREHEAT_SETPOINT  = 9'd145;
   localparam logic [DEG_W-1:0]    RST_PREHEAT_EXIT_TEMP = 9'd145;
   localparam logic [DEG_W-1:0]    RST_SOAK_SETPOINT     = 9'd160;
   localparam logic [TIMER_W-1:0]  RST_SOAK_TIME_MS      = 20'd70000;
   localparam logic [DEG_W-1:0]    RST_REFLOW_SETPOINT   = 9'd240;
   localparam logic [DEG_W-1:0]    RST_REFLOW_EXIT_TEMP  = 9'd220;
   localparam logic [DEG_W-1:0]    RST_COOL_EXIT_TEMP    = 9'd60;
   localparam logic [PERIOD_W-1:0] RST_UPDATE_PERIOD_MS  = 16'd500;

   localparam logic [ERR_W-1:0] ERR_NONE          = 4'd0;
   localparam logic [ERR_W-1:0] ERR_INVALID_STAGE = 4'd1;

   typedef struct packed {
      mode_type                  mode;
      logic                      temp_valid;
      logic signed [TEMP_W-1:0]  temperature;
      logic [ERR_W-1:0]          abort_reason;
   } req_item_type;

   typedef struct packed {
      logic [2:0]       stage;
      logic [DEG_W-1:0] setpoint;
      logic [ERR_W-1:0] error_code;
      logic             stage_evaluated;
   } rsp_item_type;

   // Whole degrees to signed sixteenths; never negative and fits 14 bits
   function automatic logic signed [TEMP_W-1:0] deg_to_temp(input logic [DEG_W-1:0] deg);
      deg_to_temp = $signed({{(TEMP_W-DEG_W-4){1'b0}}, deg, 4'b0000});
   endfunction

endpackage

// ===== design/reflow_profile_sequencer.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+---------------------------
// req      | in        | req_valid / req_stall   | rps_pkg::req_item_type
// rsp      | out       | rsp_valid / rsp_stall   | rps_pkg::rsp_item_type
// csr      | in        | csr_wen (write only)    | csr_index, csr_wdata
//
// One item is accepted per clock; its result sits in the result register from
// the next cycle. Stage, counter and threshold logic is one combinational pass.
// An item is taken while the previous result waits only if it drains this cycle;
// req_stall rises only while a result is held by rsp_stall, or during reset.
// Reset (synchronous) returns stage to idle, clears counters, temperature and
// error, and restores the register defaults.

module reflow_profile_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rps_pkg::req_item_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rps_pkg::rsp_item_type               rsp_data,
   input  logic                                csr_wen,
   input  logic [rps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rps_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rps_pkg::*;

   localparam logic [PERIOD_W-1:0] SINCE_MAX = '1;
   localparam logic [TIMER_W-1:0]  TIMER_MAX = '1;

   // Configuration registers
   logic [DEG_W-1:0]    preheat_setpoint_ff;
   logic [DEG_W-1:0]    preheat_exit_temp_ff;
   logic [DEG_W-1:0]    soak_setpoint_ff;
   logic [TIMER_W-1:0]  soak_time_ms_ff;
   logic [DEG_W-1:0]    reflow_setpoint_ff;
   logic [DEG_W-1:0]    reflow_exit_temp_ff;
   logic [DEG_W-1:0]    cool_exit_temp_ff;
   logic [PERIOD_W-1:0] update_period_ms_ff;

   // Sequencer state
   stage_type                 stage_ff,        stage_in;
   logic [DEG_W-1:0]          setpoint_ff,     setpoint_in;
   logic signed [TEMP_W-1:0]  latest_temp_ff,  latest_temp_in;
   logic [PERIOD_W-1:0]       since_update_ff, since_update_in;
   logic [TIMER_W-1:0]        stage_timer_ff,  stage_timer_in;
   logic [ERR_W-1:0]          error_ff,        error_in;
   logic                      evaluated;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_data_ff;

   logic req_accept;
   logic [PERIOD_W-1:0] since_inc;
   logic [TIMER_W-1:0]  timer_inc;

   // Hold the input while a result is stuck downstream, and during reset
   assign req_stall  = reset | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         preheat_setpoint_ff  <= RST_PREHEAT_SETPOINT;
         preheat_exit_temp_ff <= RST_PREHEAT_EXIT_TEMP;
         soak_setpoint_ff     <= RST_SOAK_SETPOINT;
         soak_time_ms_ff      <= RST_SOAK_TIME_MS;
         reflow_setpoint_ff   <= RST_REFLOW_SETPOINT;
         reflow_exit_temp_ff  <= RST_REFLOW_EXIT_TEMP;
         cool_exit_temp_ff    <= RST_COOL_EXIT_TEMP;
         update_period_ms_ff  <= RST_UPDATE_PERIOD_MS;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PREHEAT_SETPOINT:  preheat_setpoint_ff  <= csr_wdata[DEG_W-1:0];
            CSR_PREHEAT_EXIT_TEMP: preheat_exit_temp_ff <= csr_wdata[DEG_W-1:0];
            CSR_SOAK_SETPOINT:     soak_setpoint_ff     <= csr_wdata[DEG_W-1:0];
            CSR_SOAK_TIME_MS:      soak_time_ms_ff      <= csr_wdata[TIMER_W-1:0];
            CSR_REFLOW_SETPOINT:   reflow_setpoint_ff   <= csr_wdata[DEG_W-1:0];
            CSR_REFLOW_EXIT_TEMP:  reflow_exit_temp_ff  <= csr_wdata[DEG_W-1:0];
            CSR_COOL_EXIT_TEMP:    cool_exit_temp_ff    <= csr_wdata[DEG_W-1:0];
            CSR_UPDATE_PERIOD_MS:  update_period_ms_ff  <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Next state for one accepted item
   // ---------------------------------------------------------------------
   // Saturating increments used by a tick
   assign since_inc = (since_update_ff == SINCE_MAX) ? since_update_ff
                                                     : since_update_ff + 1'b1;
   assign timer_inc = (stage_timer_ff == TIMER_MAX) ? stage_timer_ff
                                                    : stage_timer_ff + 1'b1;

   always_comb begin
      stage_in        = stage_ff;
      setpoint_in     = setpoint_ff;
      latest_temp_in  = latest_temp_ff;
      since_update_in = since_update_ff;
      stage_timer_in  = stage_timer_ff;
      error_in        = error_ff;
      evaluated       = 1'b0;

      case (req_data.mode)
         MODE_TICK: begin
            // A fresh sample is used by this same evaluation
            if (req_data.temp_valid) begin
               latest_temp_in = req_data.temperature;
            end
            since_update_in = since_inc;
            stage_timer_in  = timer_inc;
            if (since_inc > update_period_ms_ff) begin
               evaluated       = 1'b1;
               since_update_in = '0;
               case (stage_ff)
                  STAGE_IDLE: ;
                  STAGE_PREHEAT: begin
                     setpoint_in = preheat_setpoint_ff;
                     if (latest_temp_in > deg_to_temp(preheat_exit_temp_ff)) begin
                        stage_in       = STAGE_SOAK;
                        stage_timer_in = '0;
                     end
                  end
                  STAGE_SOAK: begin
                     setpoint_in = soak_setpoint_ff;
                     if (timer_inc > soak_time_ms_ff) begin
                        stage_in       = STAGE_REFLOW;
                        stage_timer_in = '0;
                     end
                  end
                  STAGE_REFLOW: begin
                     setpoint_in = reflow_setpoint_ff;
                     if (latest_temp_in > deg_to_temp(reflow_exit_temp_ff)) begin
                        stage_in       = STAGE_COOL;
                        stage_timer_in = '0;
                     end
                  end
                  STAGE_COOL: begin
                     setpoint_in = '0;
                     if (latest_temp_in < deg_to_temp(cool_exit_temp_ff)) begin
                        stage_in       = STAGE_IDLE;
                        stage_timer_in = '0;
                     end
                  end
                  STAGE_ABORT: begin
                     setpoint_in = '0;
                  end
                  default: begin
                     // Unknown stage code: drop to abort
                     stage_in       = STAGE_ABORT;
                     stage_timer_in = '0;
                     error_in       = ERR_INVALID_STAGE;
                     setpoint_in    = '0;
                  end
               endcase
            end
         end
         MODE_START: begin
            stage_in       = STAGE_PREHEAT;
            stage_timer_in = '0;
         end
         MODE_ABORT: begin
            stage_in       = STAGE_ABORT;
            stage_timer_in = '0;
            error_in       = req_data.abort_reason;
         end
         MODE_CLEAR_ERR: begin
            stage_in       = STAGE_IDLE;
            stage_timer_in = '0;
            error_in       = ERR_NONE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff        <= STAGE_IDLE;
         setpoint_ff     <= '0;
         latest_temp_ff  <= '0;
         since_update_ff <= '0;
         stage_timer_ff  <= '0;
         error_ff        <= ERR_NONE;
      end else if (req_accept) begin
         stage_ff        <= stage_in;
         setpoint_ff     <= setpoint_in;
         latest_temp_ff  <= latest_temp_in;
         since_update_ff <= since_update_in;
         stage_timer_ff  <= stage_timer_in;
         error_ff        <= error_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: load on accept, hold while stalled, else drain
   // ---------------------------------------------------------------------
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff.stage           <= stage_in;
         rsp_data_ff.setpoint        <= setpoint_in;
         rsp_data_ff.error_code      <= error_in;
         rsp_data_ff.stage_evaluated <= evaluated;
      end
   end

`ifndef ASSERT_OFF
   a_accept_gives_result : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted item produced no result");

   a_event_no_eval : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.mode != MODE_TICK) |=> !rsp_data.stage_evaluated)
      else $error("evaluation flagged on a non-tick item");

   a_abort_records : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.mode == MODE_ABORT) |=>
         (rsp_data.stage == STAGE_ABORT &&
          rsp_data.error_code == $past(req_data.abort_reason)))
      else $error("abort event not recorded");

   a_eval_clears_count : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.mode == MODE_TICK) |=>
         (rsp_data.stage_evaluated == (since_update_ff == '0)))
      else $error("update counter out of step with evaluation");

   a_result_matches_state : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_data.stage == stage_ff && rsp_data.error_code == error_ff))
      else $error("result disagrees with stage state");
`endif

endmodule

// ===== tb/tb_reflow_profile_sequencer.sv =====
`timescale 1ns / 1ps

module tb_reflow_profile_sequencer;
   import rps_pkg::*;

   localparam int unsigned TARGET_ITEMS = 1450;
   localparam int unsigned QUIET_LIMIT  = 3000;  // cycles with no item moving
   localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, in cycles
   localparam int unsigned SHOW_LIMIT   = 10;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_item_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_item_type          rsp_data;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   reflow_profile_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Items waiting to be offered, and the status words the sequencer owes us
   req_item_type pending_events[$];
   rsp_item_type expected_status[$];

   // Shadow of the sequencer: stage machine, counters and register file
   stage_type              prof_stage;
   logic [DEG_W-1:0]       prof_setpoint;
   logic signed [TEMP_W-1:0] prof_temp;
   logic [PERIOD_W-1:0]    prof_since;
   logic [TIMER_W-1:0]     prof_timer;
   logic [ERR_W-1:0]       prof_error;
   logic [CSR_DATA_W-1:0]  prof_cfg [8];

   // Flow control between the stimulus process and the driver / monitor
   bit          steady_run    = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned holds_done    = 0;
   int unsigned send_gap      = 0;
   int unsigned stall_left    = 0;
   int unsigned hold_left     = 0;
   int unsigned quiet_cycles  = 0;

   // Run statistics
   int unsigned items_queued   = 0;
   int unsigned items_taken    = 0;
   int unsigned results_seen   = 0;
   int unsigned mismatch_count = 0;
   int unsigned eval_count     = 0;
   int unsigned cool_entries   = 0;
   int unsigned profiles_done  = 0;
   int unsigned settings_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length for either side: mostly none, often short, now and then long
   function automatic int unsigned idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic void enter_stage(input stage_type next);
      prof_stage = next;
      prof_timer = '0;
      if (next == STAGE_COOL) cool_entries++;
   endfunction

   // Apply one item to the shadow state and return the status it must produce
   function automatic rsp_item_type advance_profile(input req_item_type ev);
      rsp_item_type status;
      logic         evaluated;
      evaluated = 1'b0;
      case (ev.mode)
         MODE_TICK: begin
            if (ev.temp_valid) prof_temp = ev.temperature;
            if (prof_since != '1) prof_since++;
            if (prof_timer != '1) prof_timer++;
            if (CSR_DATA_W'(prof_since) > prof_cfg[CSR_UPDATE_PERIOD_MS]) begin
               evaluated  = 1'b1;
               prof_since = '0;
               eval_count++;
               // Thresholds are whole degrees; the sample is in sixteenths
               case (prof_stage)
                  STAGE_IDLE: ;
                  STAGE_PREHEAT: begin
                     prof_setpoint = prof_cfg[CSR_PREHEAT_SETPOINT][DEG_W-1:0];
                     if (int'(prof_temp) > 16 * int'(prof_cfg[CSR_PREHEAT_EXIT_TEMP]))
                        enter_stage(STAGE_SOAK);
                  end
                  STAGE_SOAK: begin
                     prof_setpoint = prof_cfg[CSR_SOAK_SETPOINT][DEG_W-1:0];
                     if (prof_timer > prof_cfg[CSR_SOAK_TIME_MS]) enter_stage(STAGE_REFLOW);
                  end
                  STAGE_REFLOW: begin
                     prof_setpoint = prof_cfg[CSR_REFLOW_SETPOINT][DEG_W-1:0];
                     if (int'(prof_temp) > 16 * int'(prof_cfg[CSR_REFLOW_EXIT_TEMP]))
                        enter_stage(STAGE_COOL);
                  end
                  STAGE_COOL: begin
                     prof_setpoint = '0;
                     if (int'(prof_temp) < 16 * int'(prof_cfg[CSR_COOL_EXIT_TEMP])) begin
                        enter_stage(STAGE_IDLE);
                        profiles_done++;
                     end
                  end
                  STAGE_ABORT: prof_setpoint = '0;
                  default: begin
                     // a corrupt stage code falls into abort
                     enter_stage(STAGE_ABORT);
                     prof_error    = ERR_INVALID_STAGE;
                     prof_setpoint = '0;
                  end
               endcase
            end
         end
         MODE_START: enter_stage(STAGE_PREHEAT);
         MODE_ABORT: begin
            enter_stage(STAGE_ABORT);
            prof_error = ev.abort_reason;
         end
         default: begin
            enter_stage(STAGE_IDLE);
            prof_error = ERR_NONE;
         end
      endcase
      status.stage           = prof_stage;
      status.setpoint        = prof_setpoint;
      status.error_code      = prof_error;
      status.stage_evaluated = evaluated;
      return status;
   endfunction

   function automatic void push_item(input mode_type m, input logic tv,
                                     input logic [TEMP_W-1:0] t, input logic [ERR_W-1:0] why);
      req_item_type ev;
      ev.mode         = m;
      ev.temp_valid   = tv;
      ev.temperature  = t;
      ev.abort_reason = why;
      pending_events.push_back(ev);
      items_queued++;
   endfunction

   // Any mode, any field value: broken sequences and out-of-place events
   function automatic void queue_noise();
      push_item(mode_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                16'($urandom), 4'($urandom));
   endfunction

   // Ticks stepping the sample from one temperature to another (sixteenths),
   // with a little jitter, some ticks without a sample and a rare stray event
   function automatic void heat_ramp(input int from, input int to, input int n);
      int   t;
      logic tv;
      for (int i = 1; i <= n; i++) begin
         t  = from + ((to - from) * i) / n + int'($urandom_range(0, 15)) - 8;
         tv = ($urandom_range(0, 9) != 0);
         if ($urandom_range(0, 79) == 0) queue_noise();
         push_item(MODE_TICK, tv, tv ? t[TEMP_W-1:0] : 16'($urandom), 4'($urandom));
      end
   endfunction

   // One full oven run: start, heat past preheat exit, hold through soak,
   // heat past reflow exit, then cool below the cooldown threshold
   function automatic void queue_profile();
      int p;
      int soak_hold;
      int top_pre;
      int top_reflow;
      int floor_cool;
      p          = (prof_cfg[CSR_UPDATE_PERIOD_MS] > 40) ? 40 : int'(prof_cfg[CSR_UPDATE_PERIOD_MS]);
      soak_hold  = (prof_cfg[CSR_SOAK_TIME_MS] > 60) ? 60 : int'(prof_cfg[CSR_SOAK_TIME_MS]);
      top_pre    = 16 * (int'(prof_cfg[CSR_PREHEAT_EXIT_TEMP]) + 4);
      top_reflow = 16 * (int'(prof_cfg[CSR_REFLOW_EXIT_TEMP]) + 6);
      floor_cool = 16 * (int'(prof_cfg[CSR_COOL_EXIT_TEMP]) - 6);
      push_item(MODE_START, 1'($urandom_range(0, 1)), 16'($urandom), 4'($urandom));
      heat_ramp(16 * 25, top_pre, $urandom_range(3, 15));
      heat_ramp(top_pre, top_pre, soak_hold + 4 * p + 6);
      heat_ramp(top_pre, top_reflow, $urandom_range(3, 15));
      heat_ramp(top_reflow, top_reflow, 2 * p + 3);
      heat_ramp(top_reflow, floor_cool, $urandom_range(3, 15));
      heat_ramp(floor_cool, floor_cool, 2 * p + 3);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_degrees(input int unsigned phase);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (phase == 0 || (phase > 2 && roll == 0)) return '0;
      if (phase <= 2 || roll == 1) return CSR_DATA_W'({DEG_W{1'b1}});
      return CSR_DATA_W'($urandom_range(20, 300));
   endfunction

   // Drive one register write; junk above the register's width must be dropped
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] wide;
      wide = value;
      case (idx)
         CSR_SOAK_TIME_MS: ;
         CSR_UPDATE_PERIOD_MS: wide[CSR_DATA_W-1:PERIOD_W] = (CSR_DATA_W-PERIOD_W)'($urandom);
         default: wide[CSR_DATA_W-1:DEG_W] = (CSR_DATA_W-DEG_W)'($urandom);
      endcase
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wide;
      prof_cfg[idx] = value;
   endtask

   task automatic program_profile(input logic [CSR_DATA_W-1:0] pre_sp, pre_exit, soak_sp,
                                  soak_ms, reflow_sp, reflow_exit, cool_exit, period);
      write_reg(CSR_PREHEAT_SETPOINT, pre_sp);
      write_reg(CSR_PREHEAT_EXIT_TEMP, pre_exit);
      write_reg(CSR_SOAK_SETPOINT, soak_sp);
      write_reg(CSR_SOAK_TIME_MS, soak_ms);
      write_reg(CSR_REFLOW_SETPOINT, reflow_sp);
      write_reg(CSR_REFLOW_EXIT_TEMP, reflow_exit);
      write_reg(CSR_COOL_EXIT_TEMP, cool_exit);
      write_reg(CSR_UPDATE_PERIOD_MS, period);
      @(posedge clock);
      csr_wen <= 1'b0;
      settings_count++;
      @(negedge clock);
   endtask

   // Hold the sender until every queued item went in and its status came out
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_valid || expected_status.size() != 0);
   endtask

   // Driver: predict on acceptance, then offer the next item or insert a gap.
   // A stalled item stays on the bus untouched.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_status.push_back(advance_profile(req_data));
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               req_data  <= pending_events.pop_front();
               req_valid <= 1'b1;
               send_gap  = steady_run ? 0 : idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted status against the oldest prediction, then
   // decide the stall for the next cycle
   always @(posedge clock) begin : status_monitor
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT)
                  $display("Unexpected status at %0t: stage %0d setpoint %0d error %0d eval %0b",
                           $realtime, rsp_data.stage, rsp_data.setpoint,
                           rsp_data.error_code, rsp_data.stage_evaluated);
            end else begin
               want = expected_status.pop_front();
               if (rsp_data.stage !== want.stage || rsp_data.setpoint !== want.setpoint ||
                   rsp_data.error_code !== want.error_code ||
                   rsp_data.stage_evaluated !== want.stage_evaluated) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOW_LIMIT)
                     $display("Mismatch on status %0d (exp/got): stage %0d/%0d setpoint %0d/%0d %s",
                              results_seen, want.stage, rsp_data.stage, want.setpoint,
                              rsp_data.setpoint,
                              $sformatf("error %0d/%0d eval %0b/%0b", want.error_code,
                                        rsp_data.error_code, want.stage_evaluated,
                                        rsp_data.stage_evaluated));
               end
            end
         end
         // A requested long hold-off overrides the ordinary random stalls
         if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = steady_run ? 0 : idle_length();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // Watchdog: give up when no item moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles, %0d status words missing",
                  quiet_cycles, expected_status.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned            phase;
      int unsigned            budget;
      int unsigned            phase_start;
      int unsigned            roll;
      bit                     paused;
      logic [CSR_DATA_W-1:0]  period;
      logic [CSR_DATA_W-1:0]  soak;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_wen   = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      prof_stage    = STAGE_IDLE;
      prof_setpoint = '0;
      prof_temp     = '0;
      prof_since    = '0;
      prof_timer    = '0;
      prof_error    = ERR_NONE;
      prof_cfg[CSR_PREHEAT_SETPOINT]  = CSR_DATA_W'(RST_PREHEAT_SETPOINT);
      prof_cfg[CSR_PREHEAT_EXIT_TEMP] = CSR_DATA_W'(RST_PREHEAT_EXIT_TEMP);
      prof_cfg[CSR_SOAK_SETPOINT]     = CSR_DATA_W'(RST_SOAK_SETPOINT);
      prof_cfg[CSR_SOAK_TIME_MS]      = RST_SOAK_TIME_MS;
      prof_cfg[CSR_REFLOW_SETPOINT]   = CSR_DATA_W'(RST_REFLOW_SETPOINT);
      prof_cfg[CSR_REFLOW_EXIT_TEMP]  = CSR_DATA_W'(RST_REFLOW_EXIT_TEMP);
      prof_cfg[CSR_COOL_EXIT_TEMP]    = CSR_DATA_W'(RST_COOL_EXIT_TEMP);
      prof_cfg[CSR_UPDATE_PERIOD_MS]  = CSR_DATA_W'(RST_UPDATE_PERIOD_MS);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Events on the reset register values: sample extremes, a tick without
      // a sample, start from idle and from abort, abort with no reason code
      push_item(MODE_TICK, 1'b1, 16'h7FFF, ERR_NONE);
      push_item(MODE_TICK, 1'b1, 16'h8000, ERR_NONE);
      push_item(MODE_TICK, 1'b0, 16'h5555, 4'hF);
      push_item(MODE_START, 1'b1, 16'hAAAA, 4'hF);
      push_item(MODE_ABORT, 1'b1, 16'hFFFF, 4'hF);
      push_item(MODE_START, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_ABORT, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_CLEAR_ERR, 1'b1, 16'h1234, 4'hF);
      push_item(MODE_ABORT, 1'b0, 16'h0000, 4'hA);
      push_item(MODE_CLEAR_ERR, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_TICK, 1'b1, 16'h0000, ERR_NONE);
      wait_idle();

      // Default update period: one evaluation once the count passes 500, hot enough
      // to leave preheat. Hold off the receiver meanwhile so the input backs up.
      push_item(MODE_START, 1'b0, 16'h0000, ERR_NONE);
      for (int i = 0; i < 505; i++) push_item(MODE_TICK, 1'b1, 16'(150 * 16 + i % 16), ERR_NONE);
      hold_requests++;
      wait_idle();

      // Period of one with extreme thresholds: sample equal to the exit
      // threshold does not leave, one sixteenth above does; zero soak time
      program_profile(20'd511, 20'd0, 20'd0, 20'd0, 20'd511, 20'd511, 20'd511, 20'd1);
      push_item(MODE_START, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_TICK, 1'b1, 16'sd0, ERR_NONE);
      push_item(MODE_TICK, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_TICK, 1'b1, 16'sd1, ERR_NONE);
      push_item(MODE_TICK, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_TICK, 1'b0, 16'hFFFF, ERR_NONE);
      push_item(MODE_TICK, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_TICK, 1'b1, 16'h7FFF, ERR_NONE);
      push_item(MODE_TICK, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_TICK, 1'b1, 16'sd8175, ERR_NONE);
      push_item(MODE_TICK, 1'b0, 16'h0000, ERR_NONE);
      push_item(MODE_TICK, 1'b1, 16'h8000, ERR_NONE);
      push_item(MODE_TICK, 1'b0, 16'h0000, ERR_NONE);
      wait_idle();

      // Random phases: first all-zero thresholds, then a period that never
      // elapses, then a soak that never ends by time; random settings after
      phase = 0;
      while (items_queued < TARGET_ITEMS) begin
         roll = $urandom_range(0, 9);
         if (phase == 0) begin
            period = CSR_DATA_W'(1);
            soak   = '0;
         end else if (phase == 1) begin
            period = CSR_DATA_W'({PERIOD_W{1'b1}});
            soak   = CSR_DATA_W'(30);
         end else if (phase == 2) begin
            period = CSR_DATA_W'(2);
            soak   = {TIMER_W{1'b1}};
         end else begin
            period = (roll < 2) ? CSR_DATA_W'(1) :
                     (roll < 8) ? CSR_DATA_W'($urandom_range(2, 6)) :
                                  CSR_DATA_W'($urandom_range(7, 40));
            soak   = ($urandom_range(0, 9) == 0) ? '0 : CSR_DATA_W'($urandom_range(1, 30));
         end
         program_profile(pick_degrees(phase), pick_degrees(phase), pick_degrees(phase), soak,
                         pick_degrees(phase), pick_degrees(phase), pick_degrees(phase), period);
         steady_run  = (phase == 3);
         budget      = (period == CSR_DATA_W'({PERIOD_W{1'b1}})) ? 60 : 150;
         phase_start = items_queued;
         paused      = 1'b0;
         while (items_queued - phase_start < budget) begin
            // once, pause the sender mid-phase until everything has drained
            if (phase == 4 && !paused && items_queued - phase_start >= budget / 2) begin
               wait_idle();
               paused = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(3, 12)) queue_noise();
            else
               queue_profile();
         end
         if (phase == 2) hold_requests++;
         wait_idle();
         phase++;
      end

      repeat (4) @(posedge clock);
      mismatch_count += expected_status.size();
      $display("Covered %0d items under %0d register settings, %0d stage evaluations,",
               items_taken, settings_count, eval_count);
      $display("%0d entries to cooldown, %0d complete profiles, %0d status words checked.",
               cool_entries, profiles_done, results_seen);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/rps_pkg.sv
design/reflow_profile_sequencer.sv
tb/tb_reflow_profile_sequencer.sv
